// ===== rtl/jst_pkg.sv =====
// Shared types and codes for the job slot table.
package jst_pkg;

	localparam int JST_MAX_JOBS = 16;
	localparam int JST_PID_BITS = 22;

	localparam int KIND_W = 2;
	localparam int PID_W  = 22;
	localparam int SLOT_W = 5;
	localparam int STAT_W = 2;

	localparam logic [KIND_W-1:0] K_ADD    = 2'd0;
	localparam logic [KIND_W-1:0] K_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] K_LOOKUP = 2'd2;
	localparam logic [KIND_W-1:0] K_LATEST = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_NONE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] slot_number;
		logic [PID_W-1:0]  slot_pid;
	} jst_res_t;

endpackage

// ===== rtl/jst_ifs.sv =====
// Request and response channel interfaces of the job slot table.
interface jst_req_if import jst_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [PID_W-1:0]  job_pid;
	logic [SLOT_W-1:0] job_index;

	modport source (output valid, kind, job_pid, job_index, input ready);
	modport sink   (input valid, kind, job_pid, job_index, output ready);
endinterface

interface jst_res_if import jst_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [SLOT_W-1:0] slot_number;
	logic [PID_W-1:0]  slot_pid;

	modport source (output valid, status, slot_number, slot_pid, input ready);
	modport sink   (input valid, status, slot_number, slot_pid, output ready);
endinterface

// ===== rtl/job_slot_table.sv =====
// Top level of the job slot table: sequencer, pid store and response register.
//
// Requests arrive as beats on req (kind, job_pid, job_index); one response beat
// per request leaves on rsp (status, slot_number, slot_pid). One request is in
// work at a time, and the next is taken while a response still waits in the
// output register.
//
// Work per request, with the scan going one slot a cycle and the pid store
// giving read data in the cycle after the address:
//   add     lowest free slot by valid bits
//   remove  one pid read a cycle, compare pipelined
//   lookup  one pid read for a valid slot
//   latest  highest valid slot by valid bits, then one read
// The next request beat is taken the cycle after the response leaves the
// sequencer.
//
// Reset clears all valid bits at once: every slot is free and the pid store
// needs no clearing. When rsp stalls, the response register holds its beat
// and the sequencer holds its finished result until the register frees.
module job_slot_table import jst_pkg::*; #(
	parameter int MAX_JOBS = JST_MAX_JOBS,
	parameter int PID_BITS = JST_PID_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	jst_req_if.sink   req,
	jst_res_if.source rsp
);

	localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

	logic                res_valid;
	logic                res_ready;
	jst_res_t            res;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [PID_BITS-1:0] mem_wdata;
	logic                mem_re;
	logic [AW-1:0]       mem_raddr;
	logic [PID_BITS-1:0] mem_rdata;

	logic                out_vld_q;
	jst_res_t            out_q;

	jst_ctrl #(
		.MAX_JOBS (MAX_JOBS),
		.PID_BITS (PID_BITS),
		.AW       (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	jst_pid_ram #(
		.DEPTH (MAX_JOBS),
		.AW    (AW),
		.W     (PID_BITS)
	) u_pid_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// take a new result when the register is empty or its beat leaves now
	assign res_ready = !out_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.status      = out_q.status;
	assign rsp.slot_number = out_q.slot_number;
	assign rsp.slot_pid    = out_q.slot_pid;

endmodule

// ===== rtl/jst_pid_ram.sv =====
// Pid store: one write port, one registered read port.
module jst_pid_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int W     = 22
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/jst_ctrl.sv =====
// Request sequencer: slot valid bits and the slot-by-slot scan.
module jst_ctrl import jst_pkg::*; #(
	parameter int MAX_JOBS = JST_MAX_JOBS,
	parameter int PID_BITS = JST_PID_BITS,
	parameter int AW       = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	jst_req_if.sink             req,
	output logic                res_valid,
	input  logic                res_ready,
	output jst_res_t            res,
	output logic                mem_we,
	output logic [AW-1:0]       mem_waddr,
	output logic [PID_BITS-1:0] mem_wdata,
	output logic                mem_re,
	output logic [AW-1:0]       mem_raddr,
	input  logic [PID_BITS-1:0] mem_rdata
);

	localparam logic [AW-1:0] LAST = AW'(MAX_JOBS - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	localparam jst_res_t RES_NONE = '{status: ST_NONE, slot_number: '0, slot_pid: '0};
	localparam jst_res_t RES_FULL = '{status: ST_FULL, slot_number: '0, slot_pid: '0};

	logic [1:0]          state_q, state_d;
	logic [KIND_W-1:0]   kind_q;
	logic [PID_BITS-1:0] pid_q;
	logic [AW-1:0]       ptr_q, ptr_d;
	logic [AW-1:0]       ptr_s1, ptr_s1_d;
	logic                chk_s1, chk_s1_d;
	logic [MAX_JOBS-1:0] valid_q, valid_d;
	jst_res_t            res_q, res_d;

	logic [AW+4:0]       lk_sum;
	logic [AW-1:0]       lk_addr;
	logic                lk_hit;

	// slot numbers count from one
	function automatic logic [SLOT_W-1:0] slot_num(input logic [AW-1:0] p);
		logic [AW:0] s;
		s = {1'b0, p} + (AW+1)'(1);
		return SLOT_W'(s);
	endfunction

	assign lk_sum  = (AW+5)'(req.job_index) - (AW+5)'(1);
	assign lk_addr = lk_sum[AW-1:0];
	assign lk_hit  = (req.job_index != '0) && (int'(req.job_index) <= MAX_JOBS)
		&& valid_q[lk_addr];

	assign req.ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	always_comb begin
		state_d   = state_q;
		ptr_d     = ptr_q;
		ptr_s1_d  = ptr_s1;
		chk_s1_d  = 1'b0;
		valid_d   = valid_q;
		res_d     = res_q;
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = pid_q;
		mem_re    = 1'b0;
		mem_raddr = ptr_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					unique case (req.kind) inside
						K_ADD, K_REMOVE: begin
							ptr_d   = '0;
							state_d = S_SCAN;
						end
						K_LATEST: begin
							ptr_d   = LAST;
							state_d = S_SCAN;
						end
						K_LOOKUP: begin
							if (lk_hit) begin
								mem_re    = 1'b1;
								mem_raddr = lk_addr;
								ptr_s1_d  = lk_addr;
								state_d   = S_READ;
							end else begin
								res_d   = RES_NONE;
								state_d = S_DONE;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_SCAN: begin
				case (kind_q)
					K_ADD: begin
						if (!valid_q[ptr_q]) begin
							mem_we         = 1'b1;
							valid_d[ptr_q] = 1'b1;
							res_d   = '{status: ST_OK, slot_number: slot_num(ptr_q),
								slot_pid: PID_W'(pid_q)};
							state_d = S_DONE;
						end else if (ptr_q == LAST) begin
							res_d   = RES_FULL;
							state_d = S_DONE;
						end else begin
							ptr_d = ptr_q + AW'(1);
						end
					end
					K_REMOVE: begin
						// issue one read a cycle, compare the previous one
						mem_re   = 1'b1;
						chk_s1_d = 1'b1;
						ptr_s1_d = ptr_q;
						if (ptr_q != LAST) begin
							ptr_d = ptr_q + AW'(1);
						end
						if (chk_s1) begin
							if (valid_q[ptr_s1] && (mem_rdata == pid_q)) begin
								valid_d[ptr_s1] = 1'b0;
								res_d   = '{status: ST_OK, slot_number: slot_num(ptr_s1),
									slot_pid: PID_W'(mem_rdata)};
								state_d = S_DONE;
							end else if (ptr_s1 == LAST) begin
								res_d   = RES_NONE;
								state_d = S_DONE;
							end
						end
					end
					K_LATEST: begin
						if (valid_q[ptr_q]) begin
							mem_re   = 1'b1;
							ptr_s1_d = ptr_q;
							state_d  = S_READ;
						end else if (ptr_q == '0) begin
							res_d   = RES_NONE;
							state_d = S_DONE;
						end else begin
							ptr_d = ptr_q - AW'(1);
						end
					end
					default: begin
						res_d   = RES_NONE;
						state_d = S_DONE;
					end
				endcase
			end
			S_READ: begin
				res_d   = '{status: ST_OK, slot_number: slot_num(ptr_s1),
					slot_pid: PID_W'(mem_rdata)};
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			chk_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= valid_d;
			chk_s1  <= chk_s1_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q  <= ptr_d;
		ptr_s1 <= ptr_s1_d;
		res_q  <= res_d;
		if (req.valid && req.ready) begin
			kind_q <= req.kind;
			pid_q  <= PID_BITS'(req.job_pid);
		end
	end

	a_we_only_add: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_SCAN) && (kind_q == K_ADD))
		else $error("pid store written outside an add scan");

	a_full_all_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res_q.status == ST_FULL)) |-> (&valid_q))
		else $error("full reported with a free slot");

	a_one_slot_change: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ($countones(valid_q) <= $countones($past(valid_q)) + 1)
			&& ($countones(valid_q) + 1 >= $countones($past(valid_q))))
		else $error("more than one slot changed in a cycle");

	a_done_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res_q.status == ST_OK)) |-> (res_q.slot_number != '0)
			|| (MAX_JOBS > 31))
		else $error("ok result without a slot number");

endmodule

// ===== tb/sv/jst_score_pkg.sv =====
// Scoreboard for the job slot table: slot-state predictor and reply checker.
package jst_score_pkg;
	import jst_pkg::*;

	class slot_scoreboard;
		bit               slot_live [JST_MAX_JOBS];
		logic [PID_W-1:0] slot_owner [JST_MAX_JOBS];
		jst_res_t         expected_replies [$];
		int unsigned      mismatches;

		function new();
			foreach (slot_live[i])
				slot_live[i] = 1'b0;
			mismatches = 0;
		endfunction

		// Work out the reply to one request and update the slot state.
		function jst_res_t predict_slot_reply(logic [KIND_W-1:0] kind,
			logic [PID_W-1:0] pid, logic [SLOT_W-1:0] idx);
			jst_res_t         reply;
			logic [PID_W-1:0] kept;
			int               i;
			reply = '{status: ST_NONE, slot_number: '0, slot_pid: '0};
			kept = pid;
			for (i = JST_PID_BITS; i < PID_W; i++)
				kept[i] = 1'b0;
			case (kind)
				K_ADD: begin
					reply.status = ST_FULL;
					for (i = 0; i < JST_MAX_JOBS; i++) begin
						if (!slot_live[i]) begin
							slot_live[i] = 1'b1;
							slot_owner[i] = kept;
							reply = '{status: ST_OK, slot_number: SLOT_W'(i + 1), slot_pid: kept};
							break;
						end
					end
				end
				K_REMOVE: begin
					for (i = 0; i < JST_MAX_JOBS; i++) begin
						if (slot_live[i] && slot_owner[i] == kept) begin
							slot_live[i] = 1'b0;
							reply = '{status: ST_OK, slot_number: SLOT_W'(i + 1),
								slot_pid: slot_owner[i]};
							break;
						end
					end
				end
				K_LOOKUP: begin
					if (idx >= 1 && idx <= JST_MAX_JOBS && slot_live[idx - 1])
						reply = '{status: ST_OK, slot_number: idx, slot_pid: slot_owner[idx - 1]};
				end
				default: begin
					for (i = JST_MAX_JOBS - 1; i >= 0; i--) begin
						if (slot_live[i]) begin
							reply = '{status: ST_OK, slot_number: SLOT_W'(i + 1),
								slot_pid: slot_owner[i]};
							break;
						end
					end
				end
			endcase
			return reply;
		endfunction

		function void note_request(logic [KIND_W-1:0] kind, logic [PID_W-1:0] pid,
			logic [SLOT_W-1:0] idx);
			expected_replies.push_back(predict_slot_reply(kind, pid, idx));
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction

		// Pid of a random occupied slot, or a random pid on an empty table.
		function logic [PID_W-1:0] live_pid();
			int picks [$];
			foreach (slot_live[i])
				if (slot_live[i])
					picks.push_back(i);
			if (picks.size() == 0)
				return PID_W'($urandom);
			return slot_owner[picks[$urandom_range(0, picks.size() - 1)]];
		endfunction

		task report(string what);
			mismatches++;
			if (mismatches <= 50)
				$display("ERROR at %0t: %s", $realtime, what);
		endtask

		task check_reply(jst_res_t got);
			jst_res_t want;
			if (expected_replies.size() == 0) begin
				report($sformatf("reply with none pending: status %0d slot %0d pid %h",
					got.status, got.slot_number, got.slot_pid));
				return;
			end
			want = expected_replies.pop_front();
			if (got.status !== want.status)
				report($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.slot_number !== want.slot_number)
				report($sformatf("slot_number %0d, want %0d", got.slot_number,
					want.slot_number));
			if (got.slot_pid !== want.slot_pid)
				report($sformatf("slot_pid %h, want %h", got.slot_pid, want.slot_pid));
		endtask
	endclass

endpackage

// ===== tb/sv/tb.sv =====
// Top-level testbench of the job slot table: clock, reset, request driver and reply sink.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import jst_pkg::*;
	import jst_score_pkg::*;

	// Generous ceiling: the slowest correct run is just over 2000 beats, each
	// a full scan plus worst gap plus worst stall.
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int          RANDOM_BEATS = 2000;
	// Hold this long after the last reply: more than one full scan.
	localparam int          DRAIN_CYCLES = 64;

	logic           clk;
	logic           arst_n;
	slot_scoreboard board;
	int unsigned    cycles;
	bit             quiet_req;
	bit             quiet_rsp;

	jst_req_if req ();
	jst_res_if rsp ();

	job_slot_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: end the run if the block hangs.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Drive one request beat and hold it until the block takes it. Valid stays
	// high after the beat, so back-to-back beats never drop it; a gap lowers
	// it first. Signals are sampled at the edge before any update lands.
	task automatic send_request(input logic [KIND_W-1:0] kind,
		input logic [PID_W-1:0] pid, input logic [SLOT_W-1:0] idx);
		int gap;
		gap = quiet_req ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid     <= 1'b1;
		req.kind      <= kind;
		req.job_pid   <= pid;
		req.job_index <= idx;
		do @(posedge clk); while (!req.ready);
		board.note_request(kind, pid, idx);
	endtask

	// Reply sink: stall a random number of cycles before each beat, with
	// stretches of full-rate acceptance, and check every beat taken.
	initial begin
		int       stall;
		int       served;
		jst_res_t got;
		served = 0;
		quiet_rsp = 1'b0;
		rsp.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (served % 50 == 0)
				quiet_rsp = ($urandom_range(0, 3) == 0);
			stall = quiet_rsp ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
			got.status      = rsp.status;
			got.slot_number = rsp.slot_number;
			got.slot_pid    = rsp.slot_pid;
			board.check_reply(got);
			served++;
		end
	end

	initial begin
		logic [PID_W-1:0]  pool [6];
		logic [KIND_W-1:0] kind;
		logic [PID_W-1:0]  pid;
		logic [SLOT_W-1:0] idx;
		int                add_pct;
		int                n;

		board = new();
		// Small pid pool so that adds make duplicate pids.
		pool = '{22'h000000, 22'h3FFFFF, 22'h2AAAAA, 22'h155555, 22'h000457, 22'h20C001};
		add_pct = 50;
		quiet_req = 1'b0;

		arst_n        = 1'b0;
		req.valid     = 1'b0;
		req.kind      = K_ADD;
		req.job_pid   = '0;
		req.job_index = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Start on the empty table: latest, remove and
		// lookups of slot zero and beyond the last slot all miss.
		send_request(K_LATEST, '0, '0);
		send_request(K_REMOVE, 22'h155555, '0);
		send_request(K_LOOKUP, '0, 5'd0);
		send_request(K_LOOKUP, '0, 5'd31);
		// Fill every slot, pid extremes first and one duplicate in slot 5.
		send_request(K_ADD, 22'h000000, '0);
		send_request(K_ADD, 22'h3FFFFF, '0);
		send_request(K_ADD, 22'h2AAAAA, '0);
		send_request(K_ADD, 22'h155555, '0);
		send_request(K_ADD, 22'h2AAAAA, '0);
		for (n = 5; n < JST_MAX_JOBS; n++)
			send_request(K_ADD, PID_W'(n * 22'h01F3A5 + 7), '0);
		// Full table: the add is refused and nothing changes.
		send_request(K_ADD, 22'h123456, '0);
		send_request(K_LOOKUP, '0, SLOT_W'(JST_MAX_JOBS));
		send_request(K_LOOKUP, '0, SLOT_W'(JST_MAX_JOBS + 1));
		send_request(K_LATEST, '0, '0);
		// Remove a duplicated pid: only the lowest copy goes, then reuse it.
		send_request(K_REMOVE, 22'h2AAAAA, '0);
		send_request(K_LOOKUP, '0, 5'd3);
		send_request(K_ADD, 22'h000001, '0);

		// Random part. Bias toward adds or removes in phases so the table
		// swings between empty and full; pick removes from live pids mostly.
		for (n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 50 == 0)
				quiet_req = ($urandom_range(0, 3) == 0);
			if (n % 150 == 0) begin
				case ($urandom_range(0, 2))
					0: add_pct = 20;
					1: add_pct = 50;
					default: add_pct = 80;
				endcase
			end
			pid = PID_W'($urandom);
			idx = SLOT_W'($urandom_range(0, 31));
			if ($urandom_range(0, 99) < add_pct) begin
				kind = K_ADD;
				if ($urandom_range(0, 1) == 0)
					pid = pool[$urandom_range(0, 5)];
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: kind = K_REMOVE;
					4, 5, 6, 7: kind = K_LOOKUP;
					default: kind = K_LATEST;
				endcase
			end
			if (kind == K_REMOVE && $urandom_range(0, 9) < 8)
				pid = board.live_pid();
			if (kind == K_LOOKUP && $urandom_range(0, 19) < 17)
				idx = SLOT_W'($urandom_range(1, JST_MAX_JOBS));
			send_request(kind, pid, idx);
		end
		req.valid <= 1'b0;

		// Drain: wait for every reply, then hold for any stray beat.
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
